@@ src/pli_pkg.sv @@
// Package for the piecewise linear interpolation core: payload structs, codes,
// sequencer states and the request/response types of the multiply-divide unit.
// No dependencies; pli_muldiv, the core and the checker import it.
`default_nettype none

package pli_pkg;

	// Fixed field widths of the channels.
	localparam int DATA_WIDTH = 32;
	localparam int PROD_W     = 2 * DATA_WIDTH;
	localparam int CFG_W      = 7;
	localparam int PIDX_W     = 6;
	localparam int SEG_W      = 6;
	localparam int STAT_W     = 2;

	// Defaults for the top-level parameters.
	localparam int MAX_POINTS_DEF = 64;
	localparam int FRAC_BITS_DEF  = 16;

	// Item function codes.
	localparam logic FUNC_LOAD  = 1'b0;
	localparam logic FUNC_QUERY = 1'b1;

	// Result status codes.
	localparam logic [STAT_W-1:0] STATUS_IN_RANGE = 2'd0;
	localparam logic [STAT_W-1:0] STATUS_BELOW    = 2'd1;
	localparam logic [STAT_W-1:0] STATUS_ABOVE    = 2'd2;
	localparam logic [STAT_W-1:0] STATUS_BAD      = 2'd3;

	typedef struct packed {
		logic                         func;
		logic [PIDX_W-1:0]            point_index;
		logic signed [DATA_WIDTH-1:0] x_value;
		logic signed [DATA_WIDTH-1:0] y_value;
	} pli_item_t;

	typedef struct packed {
		logic signed [DATA_WIDTH-1:0] interp_value;
		logic signed [DATA_WIDTH-1:0] slope_out;
		logic [SEG_W-1:0]             segment;
		logic [STAT_W-1:0]            status;
	} pli_result_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_FIRST,
		ST_LAST,
		ST_SADDR,
		ST_SCMP,
		ST_SEG,
		ST_SEG0,
		ST_SEG1,
		ST_DY,
		ST_MAG,
		ST_XD,
		ST_MULGO,
		ST_MUL,
		ST_DIV1GO,
		ST_DIV1,
		ST_VAL,
		ST_DIV2,
		ST_SLOPE,
		ST_DONE
	} pli_state_t;

	typedef enum logic {
		MDU_MUL,
		MDU_DIV
	} mdu_op_t;

	typedef struct packed {
		logic    start;
		mdu_op_t op;
	} mdu_req_t;

	typedef struct packed {
		logic done;
		logic ovf;
	} mdu_rsp_t;

endpackage

`default_nettype wire

@@ src/pli_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing; used for the breakpoint tables.
`default_nettype none

module pli_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

@@ src/pli_muldiv.sv @@
// Bit-serial unsigned multiply (shift-add) and restoring divide over one adder.
// Depends on pli_pkg for widths and the request/response structs.
`default_nettype none

module pli_muldiv import pli_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire mdu_req_t              req,
	input  wire logic [PROD_W-1:0]     num,
	input  wire logic [DATA_WIDTH-1:0] den,
	output mdu_rsp_t                   rsp,
	output logic      [PROD_W-1:0]     prod,
	output logic      [DATA_WIDTH-1:0] quo
);

	localparam int DW  = DATA_WIDTH;
	localparam int CW  = $clog2(DW + 1);
	localparam int ADW = DW + 2;

	logic           busy_q;
	mdu_op_t        op_q;
	logic [CW-1:0]  cnt_q;
	logic [DW-1:0]  acc_q;
	logic [DW-1:0]  lo_q;
	logic [DW-1:0]  den_q;
	logic           ovf_q;

	logic [ADW-1:0] add_a;
	logic [ADW-1:0] add_b;
	logic           cin;
	logic [ADW-1:0] sum;
	logic           ge;
	logic           check;
	logic           last;

	// Divide's first step tests the high half against the divisor.
	assign check = (op_q == MDU_DIV) && (cnt_q == '0);
	assign last  = (cnt_q == CW'(DW));

	always_comb begin
		case (op_q)
			MDU_MUL: begin
				add_a = ADW'(acc_q);
				add_b = lo_q[0] ? ADW'(den_q) : '0;
				cin   = 1'b0;
			end
			MDU_DIV: begin
				add_a = check ? ADW'(acc_q) : ADW'({acc_q, lo_q[DW-1]});
				add_b = ~ADW'(den_q);
				cin   = 1'b1;
			end
			default: begin
				add_a = '0;
				add_b = '0;
				cin   = 1'b0;
			end
		endcase
		sum = add_a + add_b + ADW'(cin);
		ge  = !sum[ADW-1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			op_q   <= MDU_MUL;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			op_q   <= req.op;
			cnt_q  <= (req.op == MDU_DIV) ? CW'(0) : CW'(1);
		end else if (busy_q) begin
			cnt_q <= cnt_q + CW'(1);
			if (last) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			den_q <= den;
			acc_q <= (req.op == MDU_DIV) ? num[PROD_W-1:DW] : '0;
			lo_q  <= num[DW-1:0];
			ovf_q <= 1'b0;
		end else if (busy_q) begin
			if (op_q == MDU_MUL) begin
				acc_q <= sum[DW:1];
				lo_q  <= {sum[0], lo_q[DW-1:1]};
			end else if (check) begin
				ovf_q <= ge;
			end else begin
				lo_q  <= {lo_q[DW-2:0], ge};
				acc_q <= ge ? sum[DW-1:0] : {acc_q[DW-2:0], lo_q[DW-1]};
			end
		end
	end

	assign rsp.done = busy_q && last;
	assign rsp.ovf  = ovf_q;
	assign prod     = {acc_q, lo_q};
	assign quo      = lo_q;

endmodule

`default_nettype wire

@@ src/piecewise_linear_interp_core.sv @@
// Piecewise linear interpolation core: breakpoint tables, search sequencer,
// output register. Depends on pli_pkg, pli_ram and pli_muldiv.
//
// Usage:
//   Item channel (item_valid / item_stall / item): a transfer with func = load
//   writes breakpoint point_index (x_value, y_value) in the transfer cycle and
//   gives no result; slots at or above MAX_POINTS are dropped. A transfer with
//   func = query gives exactly one result on the result channel.
//   Config channel (cfg_valid / cfg_ready / cfg_data): writes points_in_use;
//   cfg_ready is always high. Write it only while no query is in flight.
//   Flow: a load does not stall the channel; the next item may follow right away.
//   A query holds item_stall high from the cycle after its transfer until its
//   result enters the output register. This wait is set by the bit-serial unit,
//   which runs one 32-step multiply and two 33-step divides one bit per cycle,
//   and by one breakpoint read per binary search step through the registered
//   table port; x at or beyond either end point skips the search.
//   Clamped and bad-table queries skip the multiply and the divides.
//   Stall: the result sits in an output register; a new item is taken while it
//   waits, and a finished query waits in its last state until the register frees.
//   Reset: points_in_use returns to 2, the channels go idle, the breakpoint
//   tables keep no defined contents until written.
`default_nettype none

module piecewise_linear_interp_core import pli_pkg::*; #(
	parameter int MAX_POINTS = MAX_POINTS_DEF,
	parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             item_valid,
	output logic                  item_stall,
	input  wire pli_item_t        item,
	output logic                  result_valid,
	input  wire logic             result_stall,
	output pli_result_t           result,
	input  wire logic             cfg_valid,
	output logic                  cfg_ready,
	input  wire logic [CFG_W-1:0] cfg_data
);

	localparam int DW    = DATA_WIDTH;
	localparam int AW    = $clog2(MAX_POINTS);
	localparam int PW    = $clog2(MAX_POINTS + 1);
	localparam int ALU_W = DW + 2;

	localparam logic [DW-1:0] SMAX = {1'b0, {(DW-1){1'b1}}};
	localparam logic [DW-1:0] SMIN = {1'b1, {(DW-1){1'b0}}};

	pli_state_t state_q, state_d;

	// Configuration register.
	logic [CFG_W-1:0] cfg_q;

	// Item working registers.
	logic [DW-1:0]    x_q, x0_q, y0_q, y1_q;
	logic [DW:0]      dx_q, dy_q;
	logic [DW-1:0]    mag_q, xd_q;
	logic             le0_q, lt0_q, below_q, above_q;
	logic [PW-1:0]    lo_q, hi_q, md_q;
	logic [AW-1:0]    seg_q;
	logic [DW-1:0]    res_val_q, res_slope_q;
	logic [SEG_W-1:0] res_seg_q;
	logic [STAT_W-1:0] res_st_q;

	// Output register.
	logic        out_valid_q;
	pli_result_t out_q;

	// Table ports.
	logic          tab_we;
	logic [AW-1:0] tab_waddr, raddr_x, raddr_y;
	logic [DW-1:0] rdata_x, rdata_y;

	// Shared add/subtract unit of the sequencer.
	logic [ALU_W-1:0] alu_a, alu_b, alu_res;
	logic             alu_sub, alu_lt, alu_eq;

	// Multiply-divide unit.
	mdu_req_t      mdu_req;
	mdu_rsp_t      mdu_rsp;
	logic [PROD_W-1:0] mdu_num, mdu_prod;
	logic [DW-1:0] mdu_den, mdu_quo;

	logic          item_xfer, out_free, out_load;
	logic          n_bad, dx_bad, span_gt1, dy_neg, slope_sat;
	logic [PW:0]   md_sum;
	logic [PW-1:0] md;
	logic [DW-1:0] slope_val;

	assign item_stall = (state_q != ST_IDLE);
	assign item_xfer  = item_valid && !item_stall;
	assign cfg_ready  = 1'b1;

	// A load writes both tables in its transfer cycle; drop slots beyond the table.
	assign tab_we    = item_xfer && (item.func == FUNC_LOAD)
	                   && (32'(item.point_index) < 32'(MAX_POINTS));
	assign tab_waddr = AW'(item.point_index);

	pli_ram #(.WIDTH(DW), .DEPTH(MAX_POINTS)) u_ram_x (
		.clk   (clk),
		.we    (tab_we),
		.waddr (tab_waddr),
		.wdata (item.x_value),
		.raddr (raddr_x),
		.rdata (rdata_x)
	);

	pli_ram #(.WIDTH(DW), .DEPTH(MAX_POINTS)) u_ram_y (
		.clk   (clk),
		.we    (tab_we),
		.waddr (tab_waddr),
		.wdata (item.y_value),
		.raddr (raddr_y),
		.rdata (rdata_y)
	);

	pli_muldiv u_mdu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mdu_req),
		.num    (mdu_num),
		.den    (mdu_den),
		.rsp    (mdu_rsp),
		.prod   (mdu_prod),
		.quo    (mdu_quo)
	);

	// Condition flags.
	assign n_bad    = (cfg_q < CFG_W'(2)) || (32'(cfg_q) > 32'(MAX_POINTS));
	assign dx_bad   = dx_q[DW] || (dx_q == '0);
	assign span_gt1 = hi_q > (lo_q + PW'(1));
	assign md_sum   = {1'b0, lo_q} + {1'b0, hi_q};
	assign md       = md_sum[PW:1];
	assign dy_neg   = dy_q[DW];

	assign alu_res = alu_a + (alu_sub ? ~alu_b : alu_b) + ALU_W'(alu_sub);
	assign alu_lt  = alu_res[ALU_W-1];
	assign alu_eq  = (alu_res == '0);

	// Slope: saturate the quotient to the signed range, negate through the ALU.
	always_comb begin
		if (dy_neg) begin
			slope_sat = mdu_rsp.ovf || (mdu_quo[DW-1] && (mdu_quo[DW-2:0] != '0));
			slope_val = slope_sat ? SMIN : alu_res[DW-1:0];
		end else begin
			slope_sat = mdu_rsp.ovf || mdu_quo[DW-1];
			slope_val = slope_sat ? SMAX : mdu_quo;
		end
	end

	assign out_free = !out_valid_q || !result_stall;
	assign out_load = (state_q == ST_DONE) && out_free;

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (item_xfer && (item.func == FUNC_QUERY)) state_d = ST_FIRST;
			end
			ST_FIRST:  state_d = n_bad ? ST_DONE : ST_LAST;
			ST_LAST:   state_d = (le0_q || !alu_lt) ? ST_SEG : ST_SADDR;
			ST_SADDR:  state_d = span_gt1 ? ST_SCMP : ST_SEG;
			ST_SCMP:   state_d = ST_SADDR;
			ST_SEG:    state_d = ST_SEG0;
			ST_SEG0:   state_d = ST_SEG1;
			ST_SEG1:   state_d = ST_DY;
			ST_DY:     state_d = (dx_bad || below_q || above_q) ? ST_DONE : ST_MAG;
			ST_MAG:    state_d = ST_XD;
			ST_XD:     state_d = ST_MULGO;
			ST_MULGO:  state_d = ST_MUL;
			ST_MUL:    state_d = mdu_rsp.done ? ST_DIV1GO : ST_MUL;
			ST_DIV1GO: state_d = ST_DIV1;
			ST_DIV1:   state_d = mdu_rsp.done ? ST_VAL : ST_DIV1;
			ST_VAL:    state_d = ST_DIV2;
			ST_DIV2:   state_d = mdu_rsp.done ? ST_SLOPE : ST_DIV2;
			ST_SLOPE:  state_d = ST_DONE;
			ST_DONE:   state_d = out_free ? ST_IDLE : ST_DONE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// Sequencer outputs: table addresses, ALU operands, unit requests.
	always_comb begin
		raddr_x     = '0;
		raddr_y     = '0;
		alu_a       = '0;
		alu_b       = '0;
		alu_sub     = 1'b0;
		mdu_req     = '{start: 1'b0, op: MDU_MUL};
		mdu_num     = '0;
		mdu_den     = '0;
		case (state_q)
			ST_IDLE: begin
				// Idle keeps slot 0 on the read port so the first read is free.
				raddr_x = '0;
			end
			ST_FIRST: begin
				raddr_x = AW'(cfg_q - CFG_W'(1));
				alu_a   = {{2{x_q[DW-1]}}, x_q};
				alu_b   = {{2{rdata_x[DW-1]}}, rdata_x};
				alu_sub = 1'b1;
			end
			ST_LAST, ST_SCMP: begin
				alu_a   = {{2{x_q[DW-1]}}, x_q};
				alu_b   = {{2{rdata_x[DW-1]}}, rdata_x};
				alu_sub = 1'b1;
			end
			ST_SADDR: begin
				raddr_x = md[AW-1:0];
			end
			ST_SEG: begin
				raddr_x = seg_q;
				raddr_y = seg_q;
			end
			ST_SEG0: begin
				// Clamping above always returns the last ordinate of the table.
				raddr_x = seg_q + AW'(1);
				raddr_y = above_q ? AW'(cfg_q - CFG_W'(1)) : seg_q + AW'(1);
			end
			ST_SEG1: begin
				alu_a   = {{2{rdata_x[DW-1]}}, rdata_x};
				alu_b   = {{2{x0_q[DW-1]}}, x0_q};
				alu_sub = 1'b1;
			end
			ST_DY: begin
				alu_a   = {{2{y1_q[DW-1]}}, y1_q};
				alu_b   = {{2{y0_q[DW-1]}}, y0_q};
				alu_sub = 1'b1;
			end
			ST_MAG: begin
				alu_b   = {dy_q[DW], dy_q};
				alu_sub = dy_neg;
			end
			ST_XD: begin
				alu_a   = {{2{x_q[DW-1]}}, x_q};
				alu_b   = {{2{x0_q[DW-1]}}, x0_q};
				alu_sub = 1'b1;
			end
			ST_MULGO: begin
				mdu_req = '{start: 1'b1, op: MDU_MUL};
				mdu_num = PROD_W'(xd_q);
				mdu_den = mag_q;
			end
			ST_DIV1GO: begin
				mdu_req = '{start: 1'b1, op: MDU_DIV};
				mdu_num = mdu_prod;
				mdu_den = dx_q[DW-1:0];
			end
			ST_VAL: begin
				// Add the interpolation step to y0 and launch the slope divide.
				alu_a   = {{2{y0_q[DW-1]}}, y0_q};
				alu_b   = {2'b00, mdu_quo};
				alu_sub = dy_neg;
				mdu_req = '{start: 1'b1, op: MDU_DIV};
				mdu_num = PROD_W'(mag_q) << FRAC_BITS;
				mdu_den = dx_q[DW-1:0];
			end
			ST_SLOPE: begin
				alu_b   = {2'b00, mdu_quo};
				alu_sub = 1'b1;
			end
			default: begin
				raddr_x = '0;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cfg_q       <= CFG_W'(2);
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				cfg_q <= cfg_data;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Working registers of the item in flight.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (item_xfer) x_q <= item.x_value;
			end
			ST_FIRST: begin
				lt0_q <= alu_lt;
				le0_q <= alu_lt || alu_eq;
				if (n_bad) begin
					res_val_q   <= '0;
					res_slope_q <= '0;
					res_seg_q   <= '0;
					res_st_q    <= STATUS_BAD;
				end
			end
			ST_LAST: begin
				// Take the end segments directly; otherwise search the whole table.
				below_q <= le0_q && lt0_q;
				above_q <= !lt0_q && !alu_lt && !alu_eq;
				if (le0_q) begin
					seg_q <= '0;
				end else begin
					seg_q <= AW'(cfg_q - CFG_W'(2));
				end
				lo_q <= '0;
				hi_q <= PW'(cfg_q);
			end
			ST_SADDR: begin
				md_q <= md;
				if (!span_gt1) seg_q <= lo_q[AW-1:0];
			end
			ST_SCMP: begin
				if (!alu_lt) begin
					lo_q <= md_q;
				end else begin
					hi_q <= md_q;
				end
			end
			ST_SEG0: begin
				x0_q <= rdata_x;
				y0_q <= rdata_y;
			end
			ST_SEG1: begin
				y1_q <= rdata_y;
				dx_q <= alu_res[DW:0];
			end
			ST_DY: begin
				dy_q <= alu_res[DW:0];
				if (dx_bad) begin
					res_val_q   <= '0;
					res_slope_q <= '0;
					res_seg_q   <= '0;
					res_st_q    <= STATUS_BAD;
				end else if (below_q) begin
					res_val_q   <= y0_q;
					res_slope_q <= '0;
					res_seg_q   <= '0;
					res_st_q    <= STATUS_BELOW;
				end else begin
					res_val_q   <= y1_q;
					res_slope_q <= '0;
					res_seg_q   <= SEG_W'(cfg_q - CFG_W'(2));
					res_st_q    <= STATUS_ABOVE;
				end
			end
			ST_MAG: begin
				mag_q <= alu_res[DW-1:0];
			end
			ST_XD: begin
				xd_q <= alu_res[DW-1:0];
			end
			ST_VAL: begin
				res_val_q <= alu_res[DW-1:0];
			end
			ST_SLOPE: begin
				res_slope_q <= slope_val;
				res_seg_q   <= SEG_W'(seg_q);
				res_st_q    <= STATUS_IN_RANGE;
			end
			default: begin
			end
		endcase
		if (out_load) begin
			out_q.interp_value <= res_val_q;
			out_q.slope_out    <= res_slope_q;
			out_q.segment      <= res_seg_q;
			out_q.status       <= res_st_q;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

endmodule

`default_nettype wire

@@ src/pli_checker.sv @@
// Port-level checker for the piecewise linear interpolation core, bound to the
// top level. Depends on pli_pkg for the payload structs and status codes.
`default_nettype none

module pli_checker import pli_pkg::*; (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             item_valid,
	input wire logic             item_stall,
	input wire pli_item_t        item,
	input wire logic             result_valid,
	input wire logic             result_stall,
	input wire pli_result_t      result,
	input wire logic             cfg_valid,
	input wire logic             cfg_ready,
	input wire logic [CFG_W-1:0] cfg_data
);

	// Hold a stalled result.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("stalled result changed or dropped");

	// A bad table reports all-zero value, slope and segment.
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.status == STATUS_BAD)
		|-> (result.interp_value == '0) && (result.slope_out == '0)
		    && (result.segment == '0))
		else $error("bad-table result carries nonzero fields");

	// Clamping reports zero slope; below the range always uses segment zero.
	a_clamp_slope: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && ((result.status == STATUS_BELOW) || (result.status == STATUS_ABOVE))
		|-> (result.slope_out == '0)
		    && ((result.status == STATUS_ABOVE) || (result.segment == '0)))
		else $error("clamped result with nonzero slope or segment");

	// A load transfer leaves the block ready for the next item.
	a_load_ready: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall && (item.func == FUNC_LOAD) |=> !item_stall)
		else $error("block stalled after a load");

endmodule

bind piecewise_linear_interp_core pli_checker u_pli_checker (.*);

`default_nettype wire
